### sv/lph_pkg.sv
// Shared constants for the linear probing hash table core.
// Field widths, operation and status codes, hash constants; no dependencies.
package lph_pkg;

  localparam int KEY_W      = 64;
  localparam int LEN_W      = 4;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 4;
  localparam int HASH_W     = 32;
  localparam int HASH_SHIFT = 5;
  localparam int MOD_BITS   = 4;
  localparam int MOD_STEPS  = HASH_W / MOD_BITS;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

### sv/lph_home.sv
// Home slot unit: shift-add hash one character per cycle, then the hash
// reduced modulo the slot count four bits per cycle. Depends on lph_pkg.
module lph_home #(
  parameter int TABLE_SLOTS = 16,
  parameter int KEY_BYTES   = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [KEY_BYTES*8-1:0]           key,
  input  logic [lph_pkg::LEN_W-1:0]        len,
  output logic                             done,
  output logic [$clog2(TABLE_SLOTS)-1:0]   home
);

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int KW = KEY_BYTES * 8;
  localparam int CW = $clog2(lph_pkg::MOD_STEPS);
  localparam logic [AW:0] SLOTS_R = (AW + 1)'(TABLE_SLOTS);

  typedef enum logic [2:0] {
    H_IDLE = 3'b001,
    H_HASH = 3'b010,
    H_MOD  = 3'b100
  } phase_t;

  phase_t                      phase;
  logic [lph_pkg::HASH_W-1:0]  h;
  logic [KW-1:0]               key_sh;
  logic [lph_pkg::LEN_W-1:0]   rem_len;
  logic [CW-1:0]               mod_cnt;
  logic [AW-1:0]               rem;
  logic [AW-1:0]               rem_next;

  always_comb begin
    logic [AW:0]   t;
    logic [AW-1:0] r;
    r = rem;
    for (int j = 0; j < lph_pkg::MOD_BITS; j++) begin
      t = {r, h[lph_pkg::HASH_W-1-j]};
      if (t >= SLOTS_R) begin
        t = t - SLOTS_R;
      end
      r = t[AW-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= H_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (phase == H_MOD) && (mod_cnt == CW'(lph_pkg::MOD_STEPS - 1));
      unique case (phase)
        H_IDLE: begin
          if (start) begin
            phase <= H_HASH;
          end
        end
        H_HASH: begin
          if (rem_len == lph_pkg::LEN_W'(1)) begin
            phase <= H_MOD;
          end
        end
        H_MOD: begin
          if (mod_cnt == CW'(lph_pkg::MOD_STEPS - 1)) begin
            phase <= H_IDLE;
          end
        end
        default: phase <= H_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (phase)
      H_IDLE: begin
        h       <= '0;
        key_sh  <= key;
        rem_len <= len;
        rem     <= '0;
        mod_cnt <= '0;
      end
      H_HASH: begin
        h       <= (h << lph_pkg::HASH_SHIFT) + lph_pkg::HASH_W'(key_sh[7:0]);
        key_sh  <= key_sh >> 8;
        rem_len <= rem_len - lph_pkg::LEN_W'(1);
      end
      H_MOD: begin
        rem     <= rem_next;
        h       <= h << lph_pkg::MOD_BITS;
        mod_cnt <= mod_cnt + CW'(1);
      end
      default: ;
    endcase
  end

  assign home = rem;

endmodule

### sv/linear_probe_hash_table_core.sv
// Linear probing hash table: top level with the slot memory and probe control.
// Depends on lph_pkg and lph_home.
//
// Usage:
//   request channel (request_valid/request_ready) carries one insert or
//   search transaction: operation, key_chars, key_length, value.
//   result channel (result_valid/result_ready) returns one transaction per
//   request: status, read_value, slot.
// Sequence: a request with L key characters whose probe visits P slots
//   (1 to TABLE_SLOTS) is hashed over its L characters, the hash is reduced
//   modulo the slot count, the home slot is read, the P slots are checked in
//   turn through the slot memory (one read port, one write port), and the
//   result is loaded into the output register. One request is in flight at
//   a time; the next one is taken the cycle after the result is loaded.
// Reset: a clearing pass writes every slot empty, with request_ready low
//   until it finishes.
// Stall: a held result stays in the output register; a finished lookup
//   waits for it to drain before loading the next result.
module linear_probe_hash_table_core #(
  parameter int TABLE_SLOTS = 16,
  parameter int KEY_BYTES   = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                request_valid,
  output logic                                request_ready,
  input  logic                                operation,
  input  logic [lph_pkg::KEY_W-1:0]           key_chars,
  input  logic [lph_pkg::LEN_W-1:0]           key_length,
  input  logic signed [lph_pkg::VALUE_W-1:0]  value,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [lph_pkg::STATUS_W-1:0]        status,
  output logic signed [lph_pkg::VALUE_W-1:0]  read_value,
  output logic [lph_pkg::SLOT_W-1:0]          slot
);

  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int KW = KEY_BYTES * 8;
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);

  typedef struct packed {
    logic                          used;
    logic [lph_pkg::LEN_W-1:0]     len;
    logic [KW-1:0]                 key;
    logic [lph_pkg::VALUE_W-1:0]   val;
  } entry_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                         state;
  logic [AW-1:0]                  clr_addr;
  logic [AW-1:0]                  probe;
  logic [AW-1:0]                  count;
  logic                           op_reg;
  logic [KW-1:0]                  key_reg;
  logic [lph_pkg::LEN_W-1:0]      len_reg;
  logic [lph_pkg::VALUE_W-1:0]    value_reg;
  logic [lph_pkg::STATUS_W-1:0]   res_status;
  logic [lph_pkg::VALUE_W-1:0]    res_value;
  logic [lph_pkg::SLOT_W-1:0]     res_slot;

  entry_t                         mem [TABLE_SLOTS];
  entry_t                         rd_data;
  entry_t                         wr_data;
  logic                           rd_en;
  logic [AW-1:0]                  rd_addr;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;

  logic                           accept;
  logic [lph_pkg::LEN_W-1:0]      len_c;
  logic [KW-1:0]                  key_m;
  logic                           home_done;
  logic [AW-1:0]                  home;
  logic [AW-1:0]                  probe_next;
  logic                           last;
  logic                           match;
  logic                           advance;
  logic                           finish;
  logic                           out_free;

  assign request_ready = (state == S_IDLE);
  assign accept        = request_valid && request_ready;
  assign out_free      = !result_valid || result_ready;

  always_comb begin
    if (key_length == '0) begin
      len_c = lph_pkg::LEN_W'(1);
    end else if (key_length > lph_pkg::LEN_W'(KEY_BYTES)) begin
      len_c = lph_pkg::LEN_W'(KEY_BYTES);
    end else begin
      len_c = key_length;
    end
    for (int b = 0; b < KEY_BYTES; b++) begin
      key_m[8*b +: 8] = (lph_pkg::LEN_W'(b) < len_c) ? key_chars[8*b +: 8] : 8'd0;
    end
  end

  lph_home #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BYTES   (KEY_BYTES)
  ) u_home (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .key   (key_m),
    .len   (len_c),
    .done  (home_done),
    .home  (home)
  );

  assign probe_next = (probe == LAST_SLOT) ? '0 : probe + AW'(1);
  assign last       = (count == LAST_SLOT);
  assign match      = rd_data.used && (rd_data.len == len_reg) && (rd_data.key == key_reg);

  always_comb begin
    advance    = 1'b0;
    finish     = 1'b0;
    res_status = lph_pkg::ST_NOT_FOUND;
    res_value  = '0;
    res_slot   = '0;
    if (op_reg == lph_pkg::OP_INSERT) begin
      if (!rd_data.used) begin
        finish     = 1'b1;
        res_status = lph_pkg::ST_INSERTED;
        res_slot   = lph_pkg::SLOT_W'(probe);
      end else if (last) begin
        finish     = 1'b1;
        res_status = lph_pkg::ST_FULL;
      end else begin
        advance    = 1'b1;
      end
    end else begin
      if (!rd_data.used) begin
        finish     = 1'b1;
      end else if (match) begin
        finish     = 1'b1;
        res_status = lph_pkg::ST_FOUND;
        res_value  = rd_data.val;
        res_slot   = lph_pkg::SLOT_W'(probe);
      end else if (last) begin
        finish     = 1'b1;
      end else begin
        advance    = 1'b1;
      end
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = probe_next;
    if (state == S_HASH) begin
      rd_en   = home_done;
      rd_addr = home;
    end else if (state == S_CHECK) begin
      rd_en   = advance;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = probe;
    wr_data = '{used: 1'b1, len: len_reg, key: key_reg, val: value_reg};
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (state == S_CHECK) begin
      wr_en   = (op_reg == lph_pkg::OP_INSERT) && !rd_data.used;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (home_done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (finish) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg    <= operation;
      key_reg   <= key_m;
      len_reg   <= len_c;
      value_reg <= value;
    end
    if (state == S_HASH && home_done) begin
      probe <= home;
      count <= '0;
    end else if (state == S_CHECK && advance) begin
      probe <= probe_next;
      count <= count + AW'(1);
    end
    if (state == S_DONE && out_free) begin
      status     <= res_status;
      read_value <= $signed(res_value);
      slot       <= res_slot;
    end
  end

endmodule
